@@ src/evr_pkg.sv @@
// shared types, constants and helpers for the euler xyz vector rotation block
// no dependencies
package evr_pkg;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int TRIG_FRAC    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int TRIG_BITS    = 32;
  localparam int MAT_BITS     = 34;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int MATRIX_LAT   = 4;
  localparam int ROW_LAT      = 3;
  localparam int COORD_DELAY  = CORDIC_LAT + MATRIX_LAT;
  localparam int LATENCY      = COORD_DELAY + ROW_LAT;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [63:0] ROUND_HALF  = 64'sd536870912;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef logic signed [MAT_BITS-1:0] ment_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [ANGLE_BITS-1:0]        angle_about_x;
    logic [ANGLE_BITS-1:0]        angle_about_y;
    logic [ANGLE_BITS-1:0]        angle_about_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rotated_x;
    logic signed [COORD_BITS-1:0] rotated_y;
    logic signed [COORD_BITS-1:0] rotated_z;
    logic                         clipped;
  } out_t;

  // atan(2^-i) in 32-bit turn units
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // q2.30 product back to q4.30 (ment_t), round half up
  function automatic ment_t qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + ROUND_HALF) >>> TRIG_FRAC;
    return t[MAT_BITS-1:0];
  endfunction

endpackage

@@ src/evr_cordic.sv @@
// pipelined rotation-mode cordic: binary angle to cosine and sine in q2.30
// depends on evr_pkg
module evr_cordic (
  input  logic                                  clk,
  input  logic [evr_pkg::ANGLE_BITS-1:0]        angle,
  output logic signed [evr_pkg::TRIG_BITS-1:0]  cos_o,
  output logic signed [evr_pkg::TRIG_BITS-1:0]  sin_o
);

  logic signed [33:0] x_r [evr_pkg::CORDIC_STEPS+1];
  logic signed [33:0] y_r [evr_pkg::CORDIC_STEPS+1];
  logic signed [32:0] z_r [evr_pkg::CORDIC_STEPS+1];
  logic               flip_r [evr_pkg::CORDIC_STEPS+1];
  logic [31:0]        a_full;
  logic               flip_nxt;
  logic [31:0]        a_nxt;
  logic signed [33:0] cos_nxt;
  logic signed [33:0] sin_nxt;

  assign a_full   = {angle, {(32-evr_pkg::ANGLE_BITS){1'b0}}};
  assign flip_nxt = a_full[31] ^ a_full[30];
  assign a_nxt    = {a_full[31] ^ flip_nxt, a_full[30:0]};

  always_ff @(posedge clk) begin
    x_r[0]    <= evr_pkg::CORDIC_GAIN;
    y_r[0]    <= '0;
    z_r[0]    <= $signed({a_nxt[31], a_nxt});
    flip_r[0] <= flip_nxt;
  end

  for (genvar i = 0; i < evr_pkg::CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      flip_r[i+1] <= flip_r[i];
      if (!z_r[i][32]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - $signed({1'b0, evr_pkg::atan_turn(i)});
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + $signed({1'b0, evr_pkg::atan_turn(i)});
      end
    end
  end

  assign cos_nxt = flip_r[evr_pkg::CORDIC_STEPS] ? -x_r[evr_pkg::CORDIC_STEPS]
                                                 : x_r[evr_pkg::CORDIC_STEPS];
  assign sin_nxt = flip_r[evr_pkg::CORDIC_STEPS] ? -y_r[evr_pkg::CORDIC_STEPS]
                                                 : y_r[evr_pkg::CORDIC_STEPS];

  always_ff @(posedge clk) begin
    cos_o <= cos_nxt[evr_pkg::TRIG_BITS-1:0];
    sin_o <= sin_nxt[evr_pkg::TRIG_BITS-1:0];
  end

endmodule

@@ src/evr_matrix.sv @@
// four-stage merge of the three axis rotations into one 3x3 matrix
// depends on evr_pkg
module evr_matrix (
  input  logic                                 clk,
  input  logic signed [evr_pkg::TRIG_BITS-1:0] cx,
  input  logic signed [evr_pkg::TRIG_BITS-1:0] sx,
  input  logic signed [evr_pkg::TRIG_BITS-1:0] cy,
  input  logic signed [evr_pkg::TRIG_BITS-1:0] sy,
  input  logic signed [evr_pkg::TRIG_BITS-1:0] cz,
  input  logic signed [evr_pkg::TRIG_BITS-1:0] sz,
  output evr_pkg::ment_t                       m_o [9]
);

  // stage a: first products
  logic signed [63:0] czsy_a_r, szsy_a_r, czcy_a_r, szcy_a_r, cysx_a_r, cycx_a_r;
  logic signed [63:0] szcx_a_r, szsx_a_r, czcx_a_r, czsx_a_r;
  logic signed [evr_pkg::TRIG_BITS-1:0] sx_a_r, cx_a_r, sy_a_r;
  // stage b: rounded
  evr_pkg::ment_t czsy_b_r, szsy_b_r, czcy_b_r, szcy_b_r, cysx_b_r, cycx_b_r;
  evr_pkg::ment_t szcx_b_r, szsx_b_r, czcx_b_r, czsx_b_r;
  logic signed [evr_pkg::TRIG_BITS-1:0] sx_b_r, cx_b_r, sy_b_r;
  // stage c: triple products
  logic signed [63:0] p1_c_r, p2_c_r, p4_c_r, p5_c_r;
  evr_pkg::ment_t czcy_c_r, szcy_c_r, cysx_c_r, cycx_c_r;
  evr_pkg::ment_t szcx_c_r, szsx_c_r, czcx_c_r, czsx_c_r;
  logic signed [evr_pkg::TRIG_BITS-1:0] sy_c_r;

  always_ff @(posedge clk) begin
    czsy_a_r <= cz * sy;
    szsy_a_r <= sz * sy;
    czcy_a_r <= cz * cy;
    szcy_a_r <= sz * cy;
    cysx_a_r <= cy * sx;
    cycx_a_r <= cy * cx;
    szcx_a_r <= sz * cx;
    szsx_a_r <= sz * sx;
    czcx_a_r <= cz * cx;
    czsx_a_r <= cz * sx;
    sx_a_r   <= sx;
    cx_a_r   <= cx;
    sy_a_r   <= sy;

    czsy_b_r <= evr_pkg::qround(czsy_a_r);
    szsy_b_r <= evr_pkg::qround(szsy_a_r);
    czcy_b_r <= evr_pkg::qround(czcy_a_r);
    szcy_b_r <= evr_pkg::qround(szcy_a_r);
    cysx_b_r <= evr_pkg::qround(cysx_a_r);
    cycx_b_r <= evr_pkg::qround(cycx_a_r);
    szcx_b_r <= evr_pkg::qround(szcx_a_r);
    szsx_b_r <= evr_pkg::qround(szsx_a_r);
    czcx_b_r <= evr_pkg::qround(czcx_a_r);
    czsx_b_r <= evr_pkg::qround(czsx_a_r);
    sx_b_r   <= sx_a_r;
    cx_b_r   <= cx_a_r;
    sy_b_r   <= sy_a_r;

    p1_c_r   <= czsy_b_r * sx_b_r;
    p2_c_r   <= czsy_b_r * cx_b_r;
    p4_c_r   <= szsy_b_r * sx_b_r;
    p5_c_r   <= szsy_b_r * cx_b_r;
    czcy_c_r <= czcy_b_r;
    szcy_c_r <= szcy_b_r;
    cysx_c_r <= cysx_b_r;
    cycx_c_r <= cycx_b_r;
    szcx_c_r <= szcx_b_r;
    szsx_c_r <= szsx_b_r;
    czcx_c_r <= czcx_b_r;
    czsx_c_r <= czsx_b_r;
    sy_c_r   <= sy_b_r;

    m_o[0] <= czcy_c_r;
    m_o[1] <= evr_pkg::qround(p1_c_r) - szcx_c_r;
    m_o[2] <= evr_pkg::qround(p2_c_r) + szsx_c_r;
    m_o[3] <= szcy_c_r;
    m_o[4] <= evr_pkg::qround(p4_c_r) + czcx_c_r;
    m_o[5] <= evr_pkg::qround(p5_c_r) - czsx_c_r;
    m_o[6] <= -evr_pkg::ment_t'(sy_c_r);
    m_o[7] <= cysx_c_r;
    m_o[8] <= cycx_c_r;
  end

endmodule

@@ src/evr_row.sv @@
// one output row: three products, exact sum with rounding, saturation
// depends on evr_pkg
module evr_row (
  input  logic                                  clk,
  input  logic signed [evr_pkg::COORD_BITS-1:0] c0,
  input  logic signed [evr_pkg::COORD_BITS-1:0] c1,
  input  logic signed [evr_pkg::COORD_BITS-1:0] c2,
  input  evr_pkg::ment_t                        m0,
  input  evr_pkg::ment_t                        m1,
  input  evr_pkg::ment_t                        m2,
  output logic signed [evr_pkg::COORD_BITS-1:0] res_o,
  output logic                                  clip_o
);

  localparam int PW = evr_pkg::COORD_BITS + evr_pkg::MAT_BITS;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic signed [SW-1:0] acc_r;
  logic signed [SW-1:0] sh;
  logic                 fits;

  assign sh   = acc_r >>> evr_pkg::TRIG_FRAC;
  assign fits = (&sh[SW-1:evr_pkg::COORD_BITS-1]) | ~(|sh[SW-1:evr_pkg::COORD_BITS-1]);

  always_ff @(posedge clk) begin
    p0_r  <= c0 * m0;
    p1_r  <= c1 * m1;
    p2_r  <= c2 * m2;
    acc_r <= SW'(p0_r) + SW'(p1_r) + SW'(p2_r) + (SW'(1) <<< (evr_pkg::TRIG_FRAC - 1));
    if (fits) begin
      res_o <= sh[evr_pkg::COORD_BITS-1:0];
    end else begin
      res_o <= sh[SW-1] ? evr_pkg::COORD_MIN : evr_pkg::COORD_MAX;
    end
    clip_o <= ~fits;
  end

endmodule

@@ src/euler_xyz_vector_rotation.sv @@
// top level of the euler xyz vector rotation block
// depends on evr_pkg, evr_cordic, evr_matrix, evr_row
//
// rotates one q16.16 vector about x, then y, then z (v' = Rz*Ry*Rx*v)
// input: in_data holds the vector and three 16-bit binary angles
//   (65536 is one turn); a transfer happens at a clock edge with start
//   high and busy low. busy is always low: a new item may enter every cycle
// output: out_valid is high for one cycle with out_data holding the rotated
//   vector, each component rounded and saturated, and clipped set when any
//   component saturated
// pipeline: a transfer passes through the three parallel cordic pipelines
//   (one step a stage), then the matrix merge, then the row multiply, sum
//   and saturate stages before the result leaves
// throughput: one item per cycle, results leave in input order
// reset: synchronous rst_n clears the valid pipeline only; items in
//   flight are dropped
// the receiver cannot stall, so nothing ever waits inside the pipeline
module euler_xyz_vector_rotation (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  evr_pkg::in_t   in_data,
  output logic           out_valid,
  output evr_pkg::out_t  out_data
);

  logic                                  vld_r [evr_pkg::LATENCY];
  logic signed [evr_pkg::COORD_BITS-1:0] cx_r [evr_pkg::COORD_DELAY];
  logic signed [evr_pkg::COORD_BITS-1:0] cy_r [evr_pkg::COORD_DELAY];
  logic signed [evr_pkg::COORD_BITS-1:0] cz_r [evr_pkg::COORD_DELAY];
  logic signed [evr_pkg::TRIG_BITS-1:0]  cosx, sinx, cosy, siny, cosz, sinz;
  evr_pkg::ment_t                        mat [9];
  logic                                  clip_x, clip_y, clip_z;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < evr_pkg::LATENCY; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start & ~busy;
      for (int i = 1; i < evr_pkg::LATENCY; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    cx_r[0] <= in_data.coord_x;
    cy_r[0] <= in_data.coord_y;
    cz_r[0] <= in_data.coord_z;
    for (int i = 1; i < evr_pkg::COORD_DELAY; i++) begin
      cx_r[i] <= cx_r[i-1];
      cy_r[i] <= cy_r[i-1];
      cz_r[i] <= cz_r[i-1];
    end
  end

  evr_cordic u_cordic_x (.clk, .angle(in_data.angle_about_x), .cos_o(cosx), .sin_o(sinx));
  evr_cordic u_cordic_y (.clk, .angle(in_data.angle_about_y), .cos_o(cosy), .sin_o(siny));
  evr_cordic u_cordic_z (.clk, .angle(in_data.angle_about_z), .cos_o(cosz), .sin_o(sinz));

  evr_matrix u_matrix (
    .clk, .cx(cosx), .sx(sinx), .cy(cosy), .sy(siny), .cz(cosz), .sz(sinz), .m_o(mat)
  );

  evr_row u_row_x (
    .clk, .c0(cx_r[evr_pkg::COORD_DELAY-1]), .c1(cy_r[evr_pkg::COORD_DELAY-1]),
    .c2(cz_r[evr_pkg::COORD_DELAY-1]), .m0(mat[0]), .m1(mat[1]), .m2(mat[2]),
    .res_o(out_data.rotated_x), .clip_o(clip_x)
  );

  evr_row u_row_y (
    .clk, .c0(cx_r[evr_pkg::COORD_DELAY-1]), .c1(cy_r[evr_pkg::COORD_DELAY-1]),
    .c2(cz_r[evr_pkg::COORD_DELAY-1]), .m0(mat[3]), .m1(mat[4]), .m2(mat[5]),
    .res_o(out_data.rotated_y), .clip_o(clip_y)
  );

  evr_row u_row_z (
    .clk, .c0(cx_r[evr_pkg::COORD_DELAY-1]), .c1(cy_r[evr_pkg::COORD_DELAY-1]),
    .c2(cz_r[evr_pkg::COORD_DELAY-1]), .m0(mat[6]), .m1(mat[7]), .m2(mat[8]),
    .res_o(out_data.rotated_z), .clip_o(clip_z)
  );

  assign out_data.clipped = clip_x | clip_y | clip_z;
  assign out_valid        = vld_r[evr_pkg::LATENCY-1];

endmodule

@@ src/evr_checker.sv @@
// port-level checks for euler_xyz_vector_rotation, attached by bind
// depends on evr_pkg and the top level
module evr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input evr_pkg::out_t out_data
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##39 out_valid)
    else $error("transfer produced no result");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, 39))
    else $error("result without transfer");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
      (out_data.rotated_x == evr_pkg::COORD_MAX || out_data.rotated_x == evr_pkg::COORD_MIN ||
       out_data.rotated_y == evr_pkg::COORD_MAX || out_data.rotated_y == evr_pkg::COORD_MIN ||
       out_data.rotated_z == evr_pkg::COORD_MAX || out_data.rotated_z == evr_pkg::COORD_MIN))
    else $error("clipped without a saturated component");

endmodule

bind euler_xyz_vector_rotation evr_checker u_evr_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_data
);
